/* rtl/lexicographic_combination_generator_core_defines.svh */
// Assertion macros used by the core file, which checks its own behaviour.
`ifndef LEXICOGRAPHIC_COMBINATION_GENERATOR_CORE_DEFINES_SVH
`define LEXICOGRAPHIC_COMBINATION_GENERATOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lcg_pkg.sv */
package lcg_pkg;

	// Sizing of the index chain.
	localparam int SampleMax = 16;
	localparam int IndexBits = 16;
	localparam int OutLimit  = 16;
	localparam int KCap      = (SampleMax < OutLimit) ? SampleMax : OutLimit;
	localparam int PosW      = (SampleMax > 1) ? $clog2(SampleMax) : 1;
	localparam int KExtW     = 8;
	localparam int ThrW      = ((IndexBits > 16) ? IndexBits : 16) + 2;

	// Request codes carried by the mode field.
	typedef enum logic [1:0] {
		MODE_RESTART = 2'd0,
		MODE_SEED    = 2'd1,
		MODE_FIRST   = 2'd2,
		MODE_NEXT    = 2'd3
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_ELEMENT_COUNT = 2'd0,
		CFG_SAMPLE_SIZE   = 2'd1,
		CFG_BLOCK_LIMIT   = 2'd2,
		CFG_UNUSED        = 2'd3
	} cfg_index_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_UPD,
		S_EMIT,
		S_REFUSE
	} state_t;

	// Commands broadcast from the sequencer to every cell.
	typedef struct packed {
		logic restart;
		logic seed;
		logic capture;
		logic update;
	} cell_ctrl_t;

	// A cell position as an index value, wrapping at the index width.
	function automatic logic [IndexBits-1:0] pos_to_idx(input logic [PosW-1:0] p);
		logic [IndexBits+PosW-1:0] w;
		w = {{IndexBits{1'b0}}, p};
		return w[IndexBits-1:0];
	endfunction

	// Value a cell holds after restart: its one-based position.
	function automatic logic [IndexBits-1:0] init_index(input logic [PosW-1:0] p);
		return pos_to_idx(p) + IndexBits'(1);
	endfunction

	// A 16-bit seed fitted to the index width.
	function automatic logic [IndexBits-1:0] seed_to_idx(input logic [15:0] s);
		logic [IndexBits+15:0] w;
		w = {{IndexBits{1'b0}}, s};
		return w[IndexBits-1:0];
	endfunction

	// Low 16 bits of an index for the result word.
	function automatic logic [15:0] idx_to_out(input logic [IndexBits-1:0] v);
		logic [IndexBits+15:0] w;
		w = {16'b0, v};
		return w[15:0];
	endfunction

endpackage

/* rtl/lcg_cell.sv */
module lcg_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lcg_pkg::cell_ctrl_t          ctrl,
	input  logic [lcg_pkg::PosW-1:0]      cell_pos,
	input  logic                         active,
	input  logic                         seed_sel,
	input  logic [lcg_pkg::IndexBits-1:0] seed_idx,
	input  logic [lcg_pkg::ThrW-1:0]      thr,
	input  logic [lcg_pkg::IndexBits-1:0] base,
	input  logic                         all_max_in,
	input  logic [lcg_pkg::IndexBits-1:0] base_in,
	output logic                         all_max_out,
	output logic [lcg_pkg::IndexBits-1:0] base_out,
	output logic [lcg_pkg::IndexBits-1:0] idx
);

	logic [lcg_pkg::IndexBits-1:0] idx_q;
	logic                          refill_q;
	logic [lcg_pkg::ThrW-1:0]      target;
	logic                          at_max;
	logic                          pivot;
	logic [lcg_pkg::IndexBits-1:0] contrib;

	// The index is at its maximum when it equals position + n - k + 1.
	assign target = thr + lcg_pkg::ThrW'(cell_pos);
	assign at_max = (lcg_pkg::ThrW'(idx_q) == target);

	// The maximum flag ripples leftwards; inactive cells let it pass.
	assign all_max_out = all_max_in & (at_max | ~active);
	assign pivot       = active & ~at_max & all_max_in;

	// The pivot offers its incremented value less its position as the refill base.
	assign contrib  = idx_q + lcg_pkg::IndexBits'(1) - lcg_pkg::pos_to_idx(cell_pos);
	assign base_out = base_in | (pivot ? contrib : '0);

	assign idx = idx_q;

	// Index register: restart, seed write, or refill from the broadcast base.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= lcg_pkg::init_index(cell_pos);
			refill_q <= 1'b0;
		end else begin
			if (ctrl.capture) begin
				refill_q <= active & all_max_in;
			end
			if (ctrl.restart) begin
				idx_q <= lcg_pkg::init_index(cell_pos);
			end else if (ctrl.seed && seed_sel) begin
				idx_q <= seed_idx;
			end else if (ctrl.update && refill_q) begin
				idx_q <= base + lcg_pkg::pos_to_idx(cell_pos);
			end
		end
	end

endmodule

/* rtl/lexicographic_combination_generator_core.sv */
// Lexicographic k-combination generator. The indices sit in a chain of cells, one index
// per cell; restart and seed load give no word. First is accepted and then delivers its
// k words. Next runs step_count advances before its k words: every advance is a scan
// cycle, in which the at-maximum flag and the refill base ripple along the chain, and an
// update cycle, in which the pivot and every cell to its right reload themselves; the
// words then leave one per cycle through the output register while the consumer keeps
// out_ready high. A refused call loads its single word from the refusal state; a next
// that runs out of combinations goes from the update cycle that found no pivot to the
// refusal state, which loads its refusal word. A new request is taken once the last
// word of the previous call has entered the output register, so the output may still
// be waiting on out_ready. There is no clearing pass after reset.
`include "lexicographic_combination_generator_core_defines.svh"

module lexicographic_combination_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [3:0]  position,
	input  logic [15:0] seed_value,
	input  logic [15:0] step_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        valid_res,
	output logic [3:0]  slot,
	output logic [15:0] index_value,
	output logic        last
);

	logic [15:0]                    elem_q;
	logic [4:0]                     ksize_q;
	logic [15:0]                    limit_q;
	lcg_pkg::state_t                state_q;
	lcg_pkg::state_t                state_d;
	logic                           first_q;
	logic                           done_q;
	logic [15:0]                    blocks_q;
	logic [15:0]                    steps_q;
	logic [lcg_pkg::PosW-1:0]       slot_q;
	logic                           found_q;
	logic [lcg_pkg::IndexBits-1:0]  base_q;
	logic                           out_valid_q;
	logic                           vres_q;
	logic [3:0]                     oslot_q;
	logic [15:0]                    oidx_q;
	logic                           olast_q;

	lcg_pkg::mode_t                 req_mode;
	logic                           accept;
	logic                           rearm;
	logic                           load_out;
	logic                           emit_load;
	logic                           refuse_load;
	logic [lcg_pkg::KExtW-1:0]      size_ext;
	logic [lcg_pkg::KExtW-1:0]      keff;
	logic [lcg_pkg::ThrW-1:0]       thr;
	logic                           n_below_k;
	logic [15:0]                    blocks_dec;
	logic                           budget_hit;
	logic                           slot_last;
	logic [lcg_pkg::PosW+3:0]       slot_wide;
	lcg_pkg::cell_ctrl_t            cell_ctrl;
	logic [lcg_pkg::SampleMax-1:0]  seed_sel;
	logic [lcg_pkg::SampleMax-1:0]  active;
	logic [lcg_pkg::SampleMax:0]    max_chain;
	logic [lcg_pkg::IndexBits-1:0]  base_chain [lcg_pkg::SampleMax+1];
	logic [lcg_pkg::IndexBits-1:0]  idx        [lcg_pkg::SampleMax];
	logic [lcg_pkg::IndexBits-1:0]  seed_idx;

	assign req_mode = lcg_pkg::mode_t'(mode);
	assign accept   = in_valid & in_ready;
	assign rearm    = accept & ((req_mode == lcg_pkg::MODE_RESTART) ||
		(req_mode == lcg_pkg::MODE_SEED));
	assign load_out = ~out_valid_q | out_ready;
	assign seed_idx = lcg_pkg::seed_to_idx(seed_value);

	// Effective k: zero acts as one, large sizes saturate.
	assign size_ext = lcg_pkg::KExtW'(ksize_q);
	always_comb begin
		if (ksize_q == 5'd0) begin
			keff = lcg_pkg::KExtW'(1);
		end else if (size_ext > lcg_pkg::KExtW'(lcg_pkg::KCap)) begin
			keff = lcg_pkg::KExtW'(lcg_pkg::KCap);
		end else begin
			keff = size_ext;
		end
	end

	// Offset of the maximum index at each position, n - k + 1.
	assign thr       = lcg_pkg::ThrW'(elem_q) - lcg_pkg::ThrW'(keff) + lcg_pkg::ThrW'(1);
	assign n_below_k = lcg_pkg::ThrW'(elem_q) < lcg_pkg::ThrW'(keff);

	// Budget of next calls.
	assign blocks_dec = blocks_q - 16'd1;
	assign budget_hit = (blocks_q != 16'd0) && (blocks_dec == 16'd0);

	assign slot_last = (lcg_pkg::KExtW'(slot_q) + lcg_pkg::KExtW'(1)) == keff;
	assign slot_wide = {4'b0, slot_q};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q  <= 16'd0;
			ksize_q <= 5'd1;
			limit_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (lcg_pkg::cfg_index_t'(cfg_index))
				lcg_pkg::CFG_ELEMENT_COUNT: elem_q  <= cfg_data;
				lcg_pkg::CFG_SAMPLE_SIZE:   ksize_q <= cfg_data[4:0];
				lcg_pkg::CFG_BLOCK_LIMIT:   limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcg_pkg::S_IDLE: begin
				if (accept) begin
					unique case (req_mode)
						lcg_pkg::MODE_FIRST: begin
							state_d = (!first_q || done_q) ? lcg_pkg::S_REFUSE
								: lcg_pkg::S_EMIT;
						end
						lcg_pkg::MODE_NEXT: begin
							if (first_q || done_q || budget_hit) begin
								state_d = lcg_pkg::S_REFUSE;
							end else if (step_count == 16'd0) begin
								state_d = lcg_pkg::S_EMIT;
							end else begin
								state_d = lcg_pkg::S_SCAN;
							end
						end
						default: state_d = lcg_pkg::S_IDLE;
					endcase
				end
			end
			lcg_pkg::S_SCAN: state_d = lcg_pkg::S_UPD;
			lcg_pkg::S_UPD: begin
				if (!found_q) begin
					state_d = lcg_pkg::S_REFUSE;
				end else if (steps_q == 16'd1) begin
					state_d = lcg_pkg::S_EMIT;
				end else begin
					state_d = lcg_pkg::S_SCAN;
				end
			end
			lcg_pkg::S_EMIT: begin
				if (load_out && slot_last) begin
					state_d = lcg_pkg::S_IDLE;
				end
			end
			lcg_pkg::S_REFUSE: begin
				if (load_out) begin
					state_d = lcg_pkg::S_IDLE;
				end
			end
			default: state_d = lcg_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ready          = (state_q == lcg_pkg::S_IDLE);
		cell_ctrl.restart = accept && (req_mode == lcg_pkg::MODE_RESTART);
		cell_ctrl.seed    = accept && (req_mode == lcg_pkg::MODE_SEED);
		cell_ctrl.capture = (state_q == lcg_pkg::S_SCAN);
		cell_ctrl.update  = (state_q == lcg_pkg::S_UPD) && found_q;
		emit_load         = (state_q == lcg_pkg::S_EMIT) && load_out;
		refuse_load       = (state_q == lcg_pkg::S_REFUSE) && load_out;
	end

	// State, flags and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lcg_pkg::S_IDLE;
			first_q  <= 1'b1;
			done_q   <= 1'b0;
			blocks_q <= 16'd0;
			steps_q  <= 16'd0;
			slot_q   <= '0;
			found_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rearm) begin
				first_q  <= 1'b1;
				done_q   <= n_below_k;
				blocks_q <= limit_q;
			end
			if (accept && (req_mode == lcg_pkg::MODE_FIRST) && first_q && !done_q) begin
				first_q <= 1'b0;
			end
			if (accept && (req_mode == lcg_pkg::MODE_NEXT)) begin
				steps_q <= step_count;
				if (blocks_q != 16'd0) begin
					blocks_q <= blocks_dec;
				end
				if (budget_hit) begin
					done_q <= 1'b1;
				end
			end
			if (state_q == lcg_pkg::S_SCAN) begin
				found_q <= ~max_chain[0];
			end
			if (state_q == lcg_pkg::S_UPD) begin
				if (found_q) begin
					steps_q <= steps_q - 16'd1;
				end else begin
					done_q <= 1'b1;
				end
			end
			if (state_q == lcg_pkg::S_IDLE) begin
				slot_q <= '0;
			end else if (emit_load) begin
				slot_q <= slot_q + lcg_pkg::PosW'(1);
			end
		end
	end

	// Refill base captured from the chain during the scan cycle.
	always_ff @(posedge clk) begin
		if (state_q == lcg_pkg::S_SCAN) begin
			base_q <= base_chain[0];
		end
	end

	// Chain of index cells; flags and base enter at the right-hand end.
	assign max_chain[lcg_pkg::SampleMax]  = 1'b1;
	assign base_chain[lcg_pkg::SampleMax] = '0;

	for (genvar j = 0; j < lcg_pkg::SampleMax; j++) begin : g_cell
		assign active[j]   = lcg_pkg::KExtW'(j) < keff;
		assign seed_sel[j] = ({{lcg_pkg::PosW{1'b0}}, position} ==
			(lcg_pkg::PosW + 4)'(j));

		lcg_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (cell_ctrl),
			.cell_pos    (lcg_pkg::PosW'(j)),
			.active      (active[j]),
			.seed_sel    (seed_sel[j]),
			.seed_idx    (seed_idx),
			.thr         (thr),
			.base        (base_q),
			.all_max_in  (max_chain[j+1]),
			.base_in     (base_chain[j+1]),
			.all_max_out (max_chain[j]),
			.base_out    (base_chain[j]),
			.idx         (idx[j])
		);
	end

	// Output register: holds one word until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load || refuse_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			vres_q  <= 1'b1;
			oslot_q <= slot_wide[3:0];
			oidx_q  <= lcg_pkg::idx_to_out(idx[slot_q]);
			olast_q <= slot_last;
		end else if (refuse_load) begin
			vres_q  <= 1'b0;
			oslot_q <= 4'd0;
			oidx_q  <= 16'd0;
			olast_q <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign valid_res   = vres_q;
	assign slot        = oslot_q;
	assign index_value = oidx_q;
	assign last        = olast_q;

	// A refusal word is always the single, final word of its call.
	`LCG_ASSERT_SAME(a_refuse_word, clk, arst_n, out_valid_q && !vres_q, olast_q && (oslot_q == 4'd0) && (oidx_q == 16'd0), "refusal word malformed")
	// A first request on an exhausted generator must be refused.
	`LCG_ASSERT_NEXT(a_first_done, clk, arst_n, accept && (req_mode == lcg_pkg::MODE_FIRST) && done_q, state_q == lcg_pkg::S_REFUSE, "first accepted while exhausted")
	// An update cycle only ever follows a scan cycle.
	`LCG_ASSERT_SAME(a_upd_after_scan, clk, arst_n, state_q == lcg_pkg::S_UPD, $past(state_q) == lcg_pkg::S_SCAN, "update without scan")

endmodule
